>>> hdl/aes_pkg.sv
package aes_pkg;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } t_in;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } t_out;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    // Forward S-box lookup
    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    // Round constant for rounds 1..10
    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] r;
        unique case (rnd)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte n of a 128-bit block sits at bits 127-8n
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int n);
        return s[127 - 8*n -: 8];
    endfunction

endpackage

>>> hdl/aes128_block_encrypt_core.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_data (t_in: plain_high, plain_low)
// output    out        o_valid / i_stall  o_data (t_out: cipher_high, cipher_low)
// config    in         i_cfg_we           i_cfg_index, i_cfg_data (key_high, key_low)
//
// Eleven register stages: initial AddRoundKey, then one unrolled round per stage.
// One block enters per cycle when the output is not stalled. Under an output stall each stage
// still advances into an empty slot, so bubbles squeeze out; o_stall rises only when every
// stage holds a block and i_stall is high. Reset clears the valid bits and both key registers;
// each stage but the last carries its round key beside the block and expands the next one.
// The user must change the key registers only while idle; the core does not enforce it.
module aes128_block_encrypt_core import aes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    localparam int unsigned NS = NUM_ROUNDS + 1;

    logic [63:0]  r_key_high, r_key_low;
    logic [127:0] rk [NS];
    logic [127:0] r_rkey [NUM_ROUNDS];
    logic [127:0] r_state [NS];
    logic [NS-1:0] r_vld;
    logic [127:0] rnd_out [NUM_ROUNDS];
    logic [NS-1:0] adv;

    // Write key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Expand each round key from the key carried by the stage before
    assign rk[0] = {r_key_high, r_key_low};
    for (genvar g = 1; g < NS; g++) begin : g_key
        aes_key_round #(.RND(4'(g))) u_key (.i_key(r_rkey[g-1]), .o_key(rk[g]));
    end

    for (genvar g = 1; g < NS; g++) begin : g_rnd
        aes_round #(.LAST(g == NUM_ROUNDS)) u_rnd (
            .i_state(r_state[g-1]), .i_key(rk[g]), .o_state(rnd_out[g-1]));
    end

    // Stage k advances when its slot is empty or the stage after it advances
    always_comb begin
        adv[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end
    assign o_stall = !adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Move data and round keys along with valid
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_state[0] <= {i_data.plain_high, i_data.plain_low} ^ rk[0];
            r_rkey[0]  <= rk[0];
        end
        for (int k = 1; k < NS; k++) begin
            if (adv[k]) r_state[k] <= rnd_out[k-1];
        end
        for (int k = 1; k < NUM_ROUNDS; k++) begin
            if (adv[k]) r_rkey[k] <= rk[k];
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_data  = {r_state[NS-1][127:64], r_state[NS-1][63:0]};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed under stall");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output free");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0])
        else $error("accepted block lost");
endmodule

>>> hdl/aes_key_round.sv
// One key expansion step: next round key from the previous one
module aes_key_round import aes_pkg::*; #(
    parameter logic [3:0] RND = 4'd1
) (
    input  logic [127:0] i_key,
    output logic [127:0] o_key
);
    logic [31:0] w0, w1, w2, w3, t;

    always_comb begin
        w0 = i_key[127:96];
        w1 = i_key[95:64];
        w2 = i_key[63:32];
        w3 = i_key[31:0];
        t  = {sbox(w3[23:16]) ^ rcon(RND), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        o_key[127:96] = w0 ^ t;
        o_key[95:64]  = w0 ^ t ^ w1;
        o_key[63:32]  = w0 ^ t ^ w1 ^ w2;
        o_key[31:0]   = w0 ^ t ^ w1 ^ w2 ^ w3;
    end
endmodule

>>> hdl/aes_round.sv
// One cipher round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey
module aes_round import aes_pkg::*; #(
    parameter bit LAST = 1'b0
) (
    input  logic [127:0] i_state,
    input  logic [127:0] i_key,
    output logic [127:0] o_state
);
    logic [7:0] sb [16];
    logic [7:0] mc [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] res;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sb[c*4 + r] = sbox(get_byte(i_state, ((c + r) % 4) * 4 + r));
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0  = sb[c*4];
            a1  = sb[c*4 + 1];
            a2  = sb[c*4 + 2];
            a3  = sb[c*4 + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            mc[c*4]     = LAST ? a0 : a0 ^ all ^ xtime(a0 ^ a1);
            mc[c*4 + 1] = LAST ? a1 : a1 ^ all ^ xtime(a1 ^ a2);
            mc[c*4 + 2] = LAST ? a2 : a2 ^ all ^ xtime(a2 ^ a3);
            mc[c*4 + 3] = LAST ? a3 : a3 ^ all ^ xtime(a3 ^ a0);
        end
        for (int n = 0; n < 16; n++) begin
            res[127 - 8*n -: 8] = mc[n];
        end
        o_state = res ^ i_key;
    end
endmodule

>>> bench/aes128_block_encrypt_core_tb.sv
`timescale 1ns / 1ps

module aes128_block_encrypt_core_tb;
    import aes_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_data;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;

    localparam int PIPE_DEPTH = 11;
    localparam int RANDOM_BLOCKS = 1250;

    aes128_block_encrypt_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Cipher tables kept locally
    logic [7:0] sub_lut [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    logic [7:0] rnd_const [10] = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

    logic [63:0] key_hi_shadow;
    logic [63:0] key_lo_shadow;
    t_out        cipher_queue [$];
    int          error_count;
    logic        sender_hold;
    logic        sink_calm;
    logic        sink_block;

    function automatic logic [7:0] gf_mul2(logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Encrypt one block under the shadow key
    function automatic t_out encrypt_block(t_in pt);
        logic [7:0] rk [176];
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] w [4];
        logic [7:0] first, a0, a1, a2, a3, all;
        logic [127:0] kbits, pbits, cbits;
        t_out res;
        kbits = {key_hi_shadow, key_lo_shadow};
        pbits = pt;
        for (int n = 0; n < 16; n++) begin
            rk[n] = kbits[127 - 8*n -: 8];
            st[n] = pbits[127 - 8*n -: 8];
        end
        for (int i = 4; i < 44; i++) begin
            for (int n = 0; n < 4; n++) w[n] = rk[(i-1)*4 + n];
            if (i % 4 == 0) begin
                first = w[0];
                w[0] = sub_lut[w[1]] ^ rnd_const[i/4 - 1];
                w[1] = sub_lut[w[2]];
                w[2] = sub_lut[w[3]];
                w[3] = sub_lut[first];
            end
            for (int n = 0; n < 4; n++) rk[i*4 + n] = rk[(i-4)*4 + n] ^ w[n];
        end
        for (int n = 0; n < 16; n++) st[n] ^= rk[n];
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int row = 0; row < 4; row++)
                    tmp[c*4 + row] = sub_lut[st[((c + row) % 4)*4 + row]];
            st = tmp;
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[c*4]; a1 = st[c*4+1]; a2 = st[c*4+2]; a3 = st[c*4+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    st[c*4]   = a0 ^ all ^ gf_mul2(a0 ^ a1);
                    st[c*4+1] = a1 ^ all ^ gf_mul2(a1 ^ a2);
                    st[c*4+2] = a2 ^ all ^ gf_mul2(a2 ^ a3);
                    st[c*4+3] = a3 ^ all ^ gf_mul2(a3 ^ a0);
                end
            end
            for (int n = 0; n < 16; n++) st[n] ^= rk[r*16 + n];
        end
        for (int n = 0; n < 16; n++) cbits[127 - 8*n -: 8] = st[n];
        res = cbits;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Limit
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver stall: random, with a quiet stretch and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (sink_block) begin
            i_stall <= 1'b1;
        end else if (sink_calm) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 8);
        end
    end

    initial begin
        sink_block = 1'b0;
        sink_calm = 1'b0;
        wait (i_rst_n);
        repeat (500) @(posedge i_clk);
        sink_block = 1'b1;
        repeat (60) @(posedge i_clk);
        sink_block = 1'b0;
        repeat (300) @(posedge i_clk);
        sink_calm = 1'b1;
        repeat (400) @(posedge i_clk);
        sink_calm = 1'b0;
    end

    // Check each ciphertext transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (cipher_queue.size() == 0) begin
                report_mismatch("unexpected block", o_data.cipher_high, 64'h0);
            end else begin
                want = cipher_queue.pop_front();
                if (o_data.cipher_high !== want.cipher_high)
                    report_mismatch("cipher_high", o_data.cipher_high, want.cipher_high);
                if (o_data.cipher_low !== want.cipher_low)
                    report_mismatch("cipher_low", o_data.cipher_low, want.cipher_low);
            end
        end
    end

    // Offer one block and hold it until accepted
    task automatic send_block(t_in pt, logic check_known, t_out known);
        while (!sink_calm && !sender_hold && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= pt;
        cipher_queue.push_back(check_known ? known : encrypt_block(pt));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain_all();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (cipher_queue.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic load_key(logic [63:0] hi, logic [63:0] lo);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_KEY_HIGH;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_index <= CFG_KEY_LOW;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        key_hi_shadow = hi;
        key_lo_shadow = lo;
    endtask

    typedef struct {
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic        reload;
        logic [63:0] pt_hi;
        logic [63:0] pt_lo;
        logic        known;
        logic [127:0] ct;
    } t_vector_row;

    t_vector_row vectors [] = '{
        // reset key, zero block
        '{64'h0, 64'h0, 1'b0, 64'h0, 64'h0, 1'b1,
          128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
        '{64'h0, 64'h0, 1'b0, 64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 128'h0},
        '{64'h0, 64'h0, 1'b0, 64'h8000000000000000, 64'h1, 1'b0, 128'h0},
        // FIPS-197 appendix vector
        '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b1,
          64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
          128'h69c4e0d86a7b0430d8cdb78070b4c55a},
        '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b1,
          64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b1,
          128'h3925841d02dc09fbdc118597196a0b32},
        '{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b1, 64'h0, 64'h0, 1'b0, 128'h0},
        '{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b1,
          64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 128'h0},
        '{64'h0, 64'hffffffffffffffff, 1'b1, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
          1'b0, 128'h0},
        '{64'hffffffffffffffff, 64'h0, 1'b1, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
          1'b0, 128'h0}
    };

    initial begin
        t_in  pt;
        t_out known;
        error_count = 0;
        sender_hold = 1'b0;
        key_hi_shadow = '0;
        key_lo_shadow = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_KEY_HIGH;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (vectors[k]) begin
            if (vectors[k].reload) begin
                drain_all();
                load_key(vectors[k].key_hi, vectors[k].key_lo);
            end
            pt.plain_high = vectors[k].pt_hi;
            pt.plain_low = vectors[k].pt_lo;
            known = vectors[k].ct;
            send_block(pt, vectors[k].known, known);
        end

        // Random blocks, with a new key every few hundred and one full-drain pause
        for (int n = 0; n < RANDOM_BLOCKS; n++) begin
            if (n % 250 == 0) begin
                drain_all();
                load_key({$urandom, $urandom}, {$urandom, $urandom});
            end
            if (n == 900) begin
                sender_hold = 1'b1;
                drain_all();
                sender_hold = 1'b0;
            end
            pt.plain_high = {$urandom, $urandom};
            pt.plain_low = {$urandom, $urandom};
            send_block(pt, 1'b0, known);
        end
        i_valid <= 1'b0;

        while (cipher_queue.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
